// File: hdl/vdit_pkg.sv
package vdit_pkg;

    // table size and derived widths
    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int COORD_W      = 32;
    localparam int KEY_W        = 3 * COORD_W;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    // command codes of an input word
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CORNER = 2'd2;

    // status codes of a result word
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNSEEN = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    // kind of result word to build at commit
    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_FULL   = 3'd1,
        K_UNSEEN = 3'd2,
        K_VERTEX = 3'd3,
        K_CORNER = 3'd4
    } t_res_kind;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      scan_start;
        logic      scan_run;
        logic      commit;
        t_res_kind kind;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             corner_bad;
        logic             distinct_zero;
        logic             scan_hit;
        logic             scan_end;
        logic             out_free;
    } t_dp_stat;

endpackage

// File: hdl/vdit_ram.sv
module vdit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/vdit_datapath.sv
module vdit_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vdit_pkg::t_ctrl_cmd                 i_ctrl,
    output vdit_pkg::t_dp_stat                  o_stat,
    input  logic [vdit_pkg::CMD_W-1:0]          i_cmd,
    input  logic [vdit_pkg::COORD_W-1:0]        i_pos_x,
    input  logic [vdit_pkg::COORD_W-1:0]        i_pos_y,
    input  logic [vdit_pkg::COORD_W-1:0]        i_pos_z,
    input  logic [vdit_pkg::IDX_W-1:0]          i_corner_index,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [vdit_pkg::IDX_W-1:0]          o_new_index,
    output logic                                o_is_new,
    output logic [vdit_pkg::IDX_W-1:0]          o_source_index,
    output logic [vdit_pkg::CNT_W-1:0]          o_distinct_total,
    output logic [vdit_pkg::STATUS_W-1:0]       o_status
);

    // latched input word
    logic [vdit_pkg::CMD_W-1:0] r_cmd;
    logic [vdit_pkg::KEY_W-1:0] r_key;
    logic [vdit_pkg::IDX_W-1:0] r_corner;

    // table counts
    logic [vdit_pkg::CNT_W-1:0] r_vertex_count;
    logic [vdit_pkg::CNT_W-1:0] r_distinct_count;

    // scan pipeline
    logic [vdit_pkg::CNT_W-1:0] r_scan_idx;
    logic                       r_cmp_pend;
    logic [vdit_pkg::IDX_W-1:0] r_cmp_idx;
    logic                       r_match;
    logic [vdit_pkg::IDX_W-1:0] r_match_idx;

    // output register
    logic                          r_out_valid;
    logic [vdit_pkg::IDX_W-1:0]    r_new_index;
    logic                          r_is_new;
    logic [vdit_pkg::IDX_W-1:0]    r_source_index;
    logic [vdit_pkg::CNT_W-1:0]    r_distinct_total;
    logic [vdit_pkg::STATUS_W-1:0] r_status;

    // next output payload
    logic [vdit_pkg::IDX_W-1:0]    n_new_index;
    logic                          n_is_new;
    logic [vdit_pkg::IDX_W-1:0]    n_source_index;
    logic [vdit_pkg::CNT_W-1:0]    n_distinct_total;
    logic [vdit_pkg::STATUS_W-1:0] n_status;

    // memory ports
    logic [vdit_pkg::KEY_W-1:0] key_rdata;
    logic [vdit_pkg::IDX_W-1:0] map_rdata;
    logic                       key_we;
    logic                       map_we;
    logic [vdit_pkg::IDX_W-1:0] map_wdata;

    logic                       vtx_commit;
    logic                       scan_hit;
    logic                       out_free;

    assign vtx_commit = i_ctrl.commit && (i_ctrl.kind == vdit_pkg::K_VERTEX);
    assign key_we     = vtx_commit && !r_match;
    assign map_we     = vtx_commit;
    assign map_wdata  = r_match ? r_match_idx : r_distinct_count[vdit_pkg::IDX_W-1:0];

    // stored keys, one 96-bit key per new index
    vdit_ram #(
        .WIDTH (vdit_pkg::KEY_W),
        .DEPTH (vdit_pkg::MAX_VERTICES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_distinct_count[vdit_pkg::IDX_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_scan_idx[vdit_pkg::IDX_W-1:0]),
        .o_rdata (key_rdata)
    );

    // old position to new index map
    vdit_ram #(
        .WIDTH (vdit_pkg::IDX_W),
        .DEPTH (vdit_pkg::MAX_VERTICES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_vertex_count[vdit_pkg::IDX_W-1:0]),
        .i_wdata (map_wdata),
        .i_raddr (r_corner),
        .o_rdata (map_rdata)
    );

    // status towards the controller
    assign scan_hit = r_cmp_pend && (key_rdata == r_key);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.cmd           = r_cmd;
        o_stat.full          = r_vertex_count >= vdit_pkg::CNT_W'(vdit_pkg::MAX_VERTICES);
        o_stat.corner_bad    = {1'b0, r_corner} >= r_vertex_count;
        o_stat.distinct_zero = r_distinct_count == '0;
        o_stat.scan_hit      = scan_hit;
        o_stat.scan_end      = r_cmp_pend && !scan_hit
                               && (({1'b0, r_cmp_idx} + 1'b1) == r_distinct_count);
        o_stat.out_free      = out_free;
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= i_cmd;
            r_key    <= {i_pos_z, i_pos_y, i_pos_x};
            r_corner <= i_corner_index;
        end
    end

    // linear key scan, one probe issued and one compared per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_pend <= 1'b0;
            r_match    <= 1'b0;
        end else if (i_ctrl.scan_start) begin
            r_scan_idx <= '0;
            r_cmp_pend <= 1'b0;
            r_match    <= 1'b0;
        end else if (i_ctrl.scan_run) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            r_cmp_pend <= r_scan_idx < r_distinct_count;
            if (scan_hit) begin
                r_match <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_run) begin
            r_cmp_idx <= r_scan_idx[vdit_pkg::IDX_W-1:0];
            if (scan_hit) begin
                r_match_idx <= r_cmp_idx;
            end
        end
    end

    // counts update at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= '0;
            r_distinct_count <= '0;
        end else if (i_ctrl.commit) begin
            case (i_ctrl.kind)
                vdit_pkg::K_CLEAR: begin
                    r_vertex_count   <= '0;
                    r_distinct_count <= '0;
                end
                vdit_pkg::K_VERTEX: begin
                    r_vertex_count <= r_vertex_count + 1'b1;
                    if (!r_match) begin
                        r_distinct_count <= r_distinct_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload by result kind
    always_comb begin
        n_new_index      = '0;
        n_is_new         = 1'b0;
        n_source_index   = '0;
        n_distinct_total = r_distinct_count;
        n_status         = vdit_pkg::ST_OK;
        case (i_ctrl.kind)
            vdit_pkg::K_CLEAR: begin
                n_distinct_total = '0;
            end
            vdit_pkg::K_FULL: begin
                n_status = vdit_pkg::ST_FULL;
            end
            vdit_pkg::K_UNSEEN: begin
                n_status = vdit_pkg::ST_UNSEEN;
            end
            vdit_pkg::K_VERTEX: begin
                n_new_index    = map_wdata;
                n_is_new       = !r_match;
                n_source_index = r_vertex_count[vdit_pkg::IDX_W-1:0];
                if (!r_match) begin
                    n_distinct_total = r_distinct_count + 1'b1;
                end
            end
            vdit_pkg::K_CORNER: begin
                n_new_index = map_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_new_index      <= n_new_index;
            r_is_new         <= n_is_new;
            r_source_index   <= n_source_index;
            r_distinct_total <= n_distinct_total;
            r_status         <= n_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_new_index      = r_new_index;
    assign o_is_new         = r_is_new;
    assign o_source_index   = r_source_index;
    assign o_distinct_total = r_distinct_total;
    assign o_status         = r_status;

`ifndef ASSERT_OFF
    a_distinct_le_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_distinct_count <= r_vertex_count)
        else $error("distinct count above vertex count");

    a_vertex_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vertex_count <= vdit_pkg::CNT_W'(vdit_pkg::MAX_VERTICES))
        else $error("vertex count above table size");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.commit |-> out_free)
        else $error("result committed over a pending word");

    a_no_commit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan_run |-> !i_ctrl.commit)
        else $error("commit during key scan");
`endif

endmodule

// File: hdl/vdit_ctrl.sv
module vdit_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vdit_pkg::t_dp_stat   i_stat,
    output vdit_pkg::t_ctrl_cmd  o_ctrl
);

    vdit_pkg::t_state    r_state;
    vdit_pkg::t_state    n_state;
    vdit_pkg::t_res_kind r_kind;
    vdit_pkg::t_res_kind n_kind;

    // next state and commands
    always_comb begin
        n_state           = r_state;
        n_kind            = r_kind;
        o_in_ready        = 1'b0;
        o_ctrl.load       = 1'b0;
        o_ctrl.scan_start = 1'b0;
        o_ctrl.scan_run   = 1'b0;
        o_ctrl.commit     = 1'b0;
        o_ctrl.kind       = r_kind;
        case (r_state)
            vdit_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = vdit_pkg::S_EXEC;
                end
            end
            vdit_pkg::S_EXEC: begin
                case (i_stat.cmd)
                    vdit_pkg::CMD_CLEAR: begin
                        n_kind  = vdit_pkg::K_CLEAR;
                        n_state = vdit_pkg::S_RESP;
                    end
                    vdit_pkg::CMD_VERTEX: begin
                        o_ctrl.scan_start = 1'b1;
                        if (i_stat.full) begin
                            n_kind  = vdit_pkg::K_FULL;
                            n_state = vdit_pkg::S_RESP;
                        end else if (i_stat.distinct_zero) begin
                            n_kind  = vdit_pkg::K_VERTEX;
                            n_state = vdit_pkg::S_RESP;
                        end else begin
                            n_kind  = vdit_pkg::K_VERTEX;
                            n_state = vdit_pkg::S_SCAN;
                        end
                    end
                    vdit_pkg::CMD_CORNER: begin
                        n_kind  = i_stat.corner_bad ? vdit_pkg::K_UNSEEN
                                                    : vdit_pkg::K_CORNER;
                        n_state = vdit_pkg::S_RESP;
                    end
                    default: begin
                        // unused command: no result word
                        n_state = vdit_pkg::S_IDLE;
                    end
                endcase
            end
            vdit_pkg::S_SCAN: begin
                o_ctrl.scan_run = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_end) begin
                    n_state = vdit_pkg::S_RESP;
                end
            end
            vdit_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctrl.commit = 1'b1;
                    n_state       = vdit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vdit_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdit_pkg::S_IDLE;
            r_kind  <= vdit_pkg::K_CLEAR;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

// File: hdl/vertex_dedup_index_table_unit.sv
// Vertex deduplication index table. Each input word is a clear (starts a new
// mesh), a vertex key (x, y, z bit patterns compared for exact 96-bit
// equality) or a face-corner lookup, and each gives one result word; command
// code 3 is dropped with no result. One word is worked on at a time. Clear,
// table-full, corner lookups and a vertex into an empty table go from
// acceptance via the execute and response states to the result register,
// with no key scan. Any other vertex walks the stored keys in order through
// the single read port of the key memory, one key per cycle, until a match
// or the last stored key. The response state waits while the output register
// still holds a word that has not been taken.
// A result word waits in an output register without blocking acceptance of
// the next input word. No clearing pass is needed after reset or clear.
module vertex_dedup_index_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [vdit_pkg::CMD_W-1:0]        i_cmd,
    input  logic [vdit_pkg::COORD_W-1:0]      i_pos_x,
    input  logic [vdit_pkg::COORD_W-1:0]      i_pos_y,
    input  logic [vdit_pkg::COORD_W-1:0]      i_pos_z,
    input  logic [vdit_pkg::IDX_W-1:0]        i_corner_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [vdit_pkg::IDX_W-1:0]        o_new_index,
    output logic                              o_is_new,
    output logic [vdit_pkg::IDX_W-1:0]        o_source_index,
    output logic [vdit_pkg::CNT_W-1:0]        o_distinct_total,
    output logic [vdit_pkg::STATUS_W-1:0]     o_status
);

    vdit_pkg::t_ctrl_cmd ctrl;
    vdit_pkg::t_dp_stat  stat;

    // sequencing
    vdit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // tables, counts and result register
    vdit_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_cmd            (i_cmd),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_corner_index   (i_corner_index),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_new_index      (o_new_index),
        .o_is_new         (o_is_new),
        .o_source_index   (o_source_index),
        .o_distinct_total (o_distinct_total),
        .o_status         (o_status)
    );

endmodule

// File: sim/vertex_dedup_index_table_unit_test.sv
`timescale 1ns / 1ps

module vertex_dedup_index_table_unit_test;

    import vdit_pkg::*;

    // unused command code, dropped by the block with no result
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 150;
    localparam int DIRECTED_ROWS = 20;
    localparam int LONG_HOLD = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [COORD_W-1:0] ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [IDX_W-1:0]    new_index;
        logic                is_new;
        logic [IDX_W-1:0]    source_index;
        logic [CNT_W-1:0]    distinct_total;
        logic [STATUS_W-1:0] status;
    } t_remap_result;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [IDX_W-1:0]   corner;
        logic               has_fixed;
        t_remap_result      want;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd = '0;
    logic [COORD_W-1:0]  i_pos_x = '0;
    logic [COORD_W-1:0]  i_pos_y = '0;
    logic [COORD_W-1:0]  i_pos_z = '0;
    logic [IDX_W-1:0]    i_corner_index = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [IDX_W-1:0]    o_new_index;
    logic                o_is_new;
    logic [IDX_W-1:0]    o_source_index;
    logic [CNT_W-1:0]    o_distinct_total;
    logic [STATUS_W-1:0] o_status;

    // own copy of the dedup table
    logic [KEY_W-1:0]    stored_keys [MAX_VERTICES];
    logic [IDX_W-1:0]    old_to_new_map [MAX_VERTICES];
    int                  mesh_vertices = 0;
    int                  mesh_distinct = 0;

    t_remap_result       pending_results [$];
    int                  results_expected = 0;
    int                  results_checked = 0;
    int                  mismatches = 0;
    int                  idle_cycles = 0;
    int                  send_quiet = 0;
    int                  recv_quiet = 0;

    // directed words; fixed results only where obvious
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, '{10'd0, 1'b0, 10'd0, 11'd0, ST_UNSEEN}},
        '{CMD_VERTEX, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, '{10'd0, 1'b1, 10'd0, 11'd1, ST_OK}},
        '{CMD_VERTEX, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, '0},
        '{CMD_VERTEX, ONES, ONES, ONES, 10'd1023, 1'b0, '0},
        '{CMD_VERTEX, 32'h7FFF_FFFF, ONES, ONES, 10'd0, 1'b0, '0},
        '{CMD_VERTEX, 32'h0, 32'h0, 32'h8000_0000, 10'd0, 1'b0, '0},
        '{CMD_VERTEX, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, '0},
        '{CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, '0},
        '{CMD_CORNER, ONES, ONES, ONES, 10'd5, 1'b0, '0},
        '{CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd6, 1'b0, '0},
        '{CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd1023, 1'b0, '0},
        '{CMD_UNUSED, ONES, ONES, ONES, 10'd1023, 1'b0, '0},
        '{CMD_CLEAR, ONES, ONES, ONES, 10'd1023, 1'b1, '{10'd0, 1'b0, 10'd0, 11'd0, ST_OK}},
        '{CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, '{10'd0, 1'b0, 10'd0, 11'd0, ST_UNSEEN}},
        '{CMD_VERTEX, ONES, 32'h0, 32'h0, 10'd0, 1'b1, '{10'd0, 1'b1, 10'd0, 11'd1, ST_OK}},
        '{CMD_VERTEX, 32'h0, ONES, 32'h0, 10'd0, 1'b0, '0},
        '{CMD_VERTEX, 32'h0, 32'h0, ONES, 10'd0, 1'b0, '0},
        '{CMD_VERTEX, ONES, 32'h0, 32'h0, 10'd0, 1'b0, '0},
        '{CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd3, 1'b0, '0},
        '{CMD_CLEAR, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, '{10'd0, 1'b0, 10'd0, 11'd0, ST_OK}}
    };

    vertex_dedup_index_table_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_corner_index   (i_corner_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_new_index      (o_new_index),
        .o_is_new         (o_is_new),
        .o_source_index   (o_source_index),
        .o_distinct_total (o_distinct_total),
        .o_status         (o_status)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // idle cycles before the next word, with runs of back-to-back words
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // remap one word against the table copy; returns 0 when no result follows
    function automatic bit remap_word(input logic [CMD_W-1:0] cmd,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [COORD_W-1:0] z,
                                      input logic [IDX_W-1:0] corner,
                                      output t_remap_result res);
        logic [KEY_W-1:0] key;
        int hit;
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                mesh_vertices = 0;
                mesh_distinct = 0;
                return 1'b1;
            end
            CMD_VERTEX: begin
                res.distinct_total = CNT_W'(mesh_distinct);
                if (mesh_vertices >= MAX_VERTICES) begin
                    res.status = ST_FULL;
                    return 1'b1;
                end
                key = {z, y, x};
                hit = mesh_distinct;
                for (int k = 0; k < mesh_distinct; k++) begin
                    if (stored_keys[k] == key) begin
                        hit = k;
                        break;
                    end
                end
                // first sighting takes the next new index
                if (hit == mesh_distinct) begin
                    stored_keys[hit] = key;
                    mesh_distinct++;
                    res.is_new = 1'b1;
                end
                res.new_index = IDX_W'(hit);
                res.source_index = IDX_W'(mesh_vertices);
                old_to_new_map[mesh_vertices] = IDX_W'(hit);
                mesh_vertices++;
                res.distinct_total = CNT_W'(mesh_distinct);
                res.status = ST_OK;
                return 1'b1;
            end
            CMD_CORNER: begin
                res.distinct_total = CNT_W'(mesh_distinct);
                if (int'(corner) >= mesh_vertices)
                    res.status = ST_UNSEEN;
                else
                    res.new_index = old_to_new_map[corner];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // present one word, wait for acceptance, then log its expected result
    task automatic offer_word(input logic [CMD_W-1:0] cmd,
                              input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z,
                              input logic [IDX_W-1:0] corner,
                              input logic has_fixed,
                              input t_remap_result fixed_result);
        int gap;
        t_remap_result res;
        gap = draw_gap(send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_pos_x = x;
        i_pos_y = y;
        i_pos_z = z;
        i_corner_index = corner;
        do @(posedge i_clk); while (!o_in_ready);
        if (remap_word(cmd, x, y, z, corner, res)) begin
            pending_results.push_back(has_fixed ? fixed_result : res);
            results_expected++;
        end
    endtask

    // drop valid and hold off until every expected word has come back
    task automatic pause_until_drained;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (results_checked == results_expected);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // result checking against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_remap_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result word with none expected, index %0d status %0d",
                         $time, o_new_index, o_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                compare_field("new_index", want.new_index, o_new_index);
                compare_field("is_new", want.is_new, o_is_new);
                compare_field("source_index", want.source_index, o_source_index);
                compare_field("distinct_total", want.distinct_total, o_distinct_total);
                compare_field("status", want.status, o_status);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, two long hold-offs to back up the input
    initial begin : drive_out_ready
        int gap;
        int delivered;
        delivered = 0;
        wait (i_rst_n);
        forever begin
            if (delivered == 60 || delivered == 1100)
                gap = LONG_HOLD;
            else
                gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            delivered++;
        end
    end

    // word side
    initial begin : drive_words
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] key_pool [$];
        logic [CMD_W-1:0] noise_cmd;
        t_stim_row row;
        int steps;
        int pick;
        int flip_pos;
        int random_words;

        // reset held low at start, then released
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            offer_word(row.cmd, row.x, row.y, row.z, row.corner, row.has_fixed, row.want);
        end
        pause_until_drained();

        // fill one mesh to the limit with distinct keys, then overflow
        offer_word(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, '0);
        for (int v = 0; v < MAX_VERTICES; v++)
            offer_word(CMD_VERTEX, $urandom, $urandom, {22'($urandom), 10'(v)},
                       10'($urandom), 1'b0, '0);
        repeat (3)
            offer_word(CMD_VERTEX, $urandom, $urandom, $urandom, 10'($urandom), 1'b0, '0);
        offer_word(CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd1023, 1'b0, '0);
        offer_word(CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, '0);
        repeat (4)
            offer_word(CMD_CORNER, 32'h0, 32'h0, 32'h0, 10'($urandom), 1'b0, '0);
        pause_until_drained();

        // random meshes: mostly clear plus pooled keys, some noise in between
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 85) begin
                // now and then a mesh carries on without a clear
                if ($urandom_range(0, 6) != 0) begin
                    offer_word(CMD_CLEAR, $urandom, $urandom, $urandom, 10'($urandom),
                               1'b0, '0);
                    random_words++;
                end
                key_pool.delete();
                repeat ($urandom_range(1, 12))
                    key_pool.push_back({$urandom, $urandom, $urandom});
                steps = $urandom_range(1, 40);
                repeat (steps) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55) begin
                        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                        pick = $urandom_range(0, 99);
                        // pooled key, fresh key, or a near miss one bit away from a pooled one
                        if (pick < 20) begin
                            key = {$urandom, $urandom, $urandom};
                        end else if (pick < 30) begin
                            flip_pos = $urandom_range(0, KEY_W - 1);
                            key[flip_pos] = ~key[flip_pos];
                        end
                        offer_word(CMD_VERTEX, key[31:0], key[63:32], key[95:64],
                                   10'($urandom), 1'b0, '0);
                        random_words++;
                    end else if (pick < 88 && mesh_vertices > 0) begin
                        offer_word(CMD_CORNER, $urandom, $urandom, $urandom,
                                   10'($urandom_range(0, mesh_vertices - 1)), 1'b0, '0);
                        random_words++;
                    end else if (pick < 97) begin
                        offer_word(CMD_CORNER, $urandom, $urandom, $urandom,
                                   10'($urandom), 1'b0, '0);
                        random_words++;
                    end else begin
                        offer_word(CMD_UNUSED, $urandom, $urandom, $urandom,
                                   10'($urandom), 1'b0, '0);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    noise_cmd = CMD_W'($urandom_range(0, 3));
                    offer_word(noise_cmd, $urandom, $urandom, $urandom, 10'($urandom),
                               1'b0, '0);
                    if (noise_cmd != CMD_UNUSED)
                        random_words++;
                end
            end
        end

        // drain, then wait for anything stray before the verdict
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hdl/vdit_pkg.sv
hdl/vdit_ram.sv
hdl/vdit_datapath.sv
hdl/vdit_ctrl.sv
hdl/vertex_dedup_index_table_unit.sv
sim/vertex_dedup_index_table_unit_test.sv
